// ===== rtl/skt_pkg.sv =====
package skt_pkg;

    localparam int SKT_CAPACITY = 8;
    localparam int SKT_KEY_W    = 34;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_DUP  = 2'd2;
    localparam logic [1:0] STAT_MISS = 2'd3;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // latch compare flags against the request key
        logic ins;   // open a slot at the insertion point, shift larger keys up
        logic del;   // drop the matching key, shift larger keys down
    } t_cell_ctl;

endpackage

// ===== rtl/skt_cell.sv =====
module skt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skt_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_valid,     // slot holds a key
    input  logic [skt_pkg::SKT_KEY_W-1:0] i_req_key,
    input  logic [skt_pkg::SKT_KEY_W-1:0] i_prev_key,  // key of the cell below
    input  logic [skt_pkg::SKT_KEY_W-1:0] i_next_key,  // key of the cell above
    input  logic                          i_prev_lt,   // cell below holds a smaller key
    output logic [skt_pkg::SKT_KEY_W-1:0] o_key,
    output logic                          o_lt,
    output logic                          o_eq
);
    import skt_pkg::*;

    logic [SKT_KEY_W-1:0] r_key;
    logic                 r_lt;
    logic                 r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_key < i_req_key);
            r_eq <= i_valid && (r_key == i_req_key);
        end
    end

    // Keys stay sorted, so the cells with lt clear form the upper part of the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_req_key : i_prev_key;
        end else if (i_ctl.del && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: holds up to CAPACITY unique 34-bit keys in ascending
// order in a row of cells. A request is an insert, remove, search or clear
// (tuser) of a key (tdata); each gives one result with status, position and
// the key count after the request. A request is accepted in the idle state;
// in the compare state every cell compares its key against the request, and
// the update state shifts the row and registers the result, waiting while an
// earlier result is still held downstream. The next request is taken in the
// cycle after its predecessor's result is registered, while that result may
// still wait for the downstream side.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::SKT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [33:0] card_number, [39:34] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [1:0] status, [4:2] position,
                                     // [8:5] entry_count, [15:9] zero
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_req;
    logic [SKT_KEY_W-1:0] r_key;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_valid;
    logic [1:0]           r_status, n_status;
    logic [2:0]           r_pos, n_pos;
    logic [3:0]           r_cnt_out;

    logic [SKT_KEY_W-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    logic                 s_fire;
    logic                 upd_fire;
    logic                 full;
    logic                 found;
    logic [SUM_W-1:0]     lt_sum;
    logic [SUM_W-1:0]     cnt_ext;
    t_cell_ctl            ctl;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign upd_fire   = (r_state == S_UPD) && (!r_out_valid || i_m_tready);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign found      = |w_eq;

    // Insertion point and match slot are both the number of smaller keys
    always_comb begin
        lt_sum = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lt_sum = lt_sum + SUM_W'(w_lt[i]);
        end
    end

    always_comb begin
        ctl.cmp  = (r_state == S_CMP);
        ctl.ins  = 1'b0;
        ctl.del  = 1'b0;
        n_count  = r_count;
        n_status = STAT_OK;
        n_pos    = 3'd0;
        case (r_req)
            REQ_INSERT: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else if (found) begin
                    n_status = STAT_DUP;
                end else begin
                    ctl.ins = upd_fire;
                    n_count = r_count + CNT_W'(1);
                    n_pos   = lt_sum[2:0];
                end
            end
            REQ_REMOVE: begin
                if (found) begin
                    ctl.del = upd_fire;
                    n_count = r_count - CNT_W'(1);
                    n_pos   = lt_sum[2:0];
                end else begin
                    n_status = STAT_MISS;
                end
            end
            REQ_SEARCH: begin
                if (found) begin
                    n_pos = lt_sum[2:0];
                end else begin
                    n_status = STAT_MISS;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_fire) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (upd_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign cnt_ext = SUM_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_req <= i_s_tuser;
            r_key <= i_s_tdata[SKT_KEY_W-1:0];
        end
        if (upd_fire) begin
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_cnt_out <= cnt_ext[3:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [SKT_KEY_W-1:0] prev_key;
            logic [SKT_KEY_W-1:0] next_key;
            logic                 prev_lt;
            if (g == 0) begin : g_first
                assign prev_key = r_key;
                assign prev_lt  = 1'b1;
            end else begin : g_mid
                assign prev_key = w_key[g-1];
                assign prev_lt  = w_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign next_key = w_key[g];
            end else begin : g_inner
                assign next_key = w_key[g+1];
            end
            skt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_valid    (r_count > CNT_W'(g)),
                .i_req_key  (r_key),
                .i_prev_key (prev_key),
                .i_next_key (next_key),
                .i_prev_lt  (prev_lt),
                .o_key      (w_key[g]),
                .o_lt       (w_lt[g]),
                .o_eq       (w_eq[g])
            );
        end
    endgenerate

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_cnt_out, r_pos, r_status};

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_eq))
        else $error("key matched in more than one cell");

    a_sorted_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> ((w_lt & ~(w_lt << 1) & ~CAPACITY'(1)) == '0))
        else $error("smaller-key flags not contiguous from slot 0");

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (r_out_valid && r_state == S_IDLE))
        else $error("update did not produce a result");

endmodule

// ===== sim/tb_sorted_key_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam logic [33:0] KEY_MAX = 34'h3_FFFF_FFFF;
    localparam logic [33:0] KEY_TOP = 34'd9999999999;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] position;
        logic [3:0] count;
    } t_table_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // [33:0] card_number, [39:34] zero
    logic [1:0]  i_s_tuser;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [1:0] status, [4:2] position, [8:5] entry_count

    // shadow copy of the table, updated at each accepted request
    logic [33:0]   shadow_keys [SKT_CAPACITY];
    int            shadow_count;
    t_table_result pending_results[$];

    int  error_count;
    int  cycle_count = 0;
    bit  tx_no_gap;
    bit  rx_no_gap;
    int  rx_hold;
    int  insert_pct;

    sorted_key_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $realtime, msg);
        error_count++;
    endtask

    // Sorted-set update: returns status/position/count and advances the shadow table
    function automatic t_table_result apply_request(input logic [1:0] req,
                                                    input logic [33:0] key);
        t_table_result r;
        int hit;
        int slot;
        int i;
        r = '0;
        hit = -1;
        for (i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_keys[i] == key) hit = i;
        case (req)
            REQ_INSERT: begin
                if (shadow_count >= SKT_CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (hit >= 0) begin
                    r.status = STAT_DUP;
                end else begin
                    slot = 0;
                    while (slot < shadow_count && shadow_keys[slot] < key) slot++;
                    for (i = shadow_count; i > slot; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[slot] = key;
                    shadow_count++;
                    r.status = STAT_OK;
                    r.position = slot[2:0];
                end
            end
            REQ_REMOVE: begin
                if (hit < 0) begin
                    r.status = STAT_MISS;
                end else begin
                    for (i = hit; i + 1 < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    r.status = STAT_OK;
                    r.position = hit[2:0];
                end
            end
            REQ_SEARCH: begin
                if (hit < 0) begin
                    r.status = STAT_MISS;
                end else begin
                    r.status = STAT_OK;
                    r.position = hit[2:0];
                end
            end
            default: begin
                shadow_count = 0;
                r.status = STAT_OK;
            end
        endcase
        r.count = shadow_count[3:0];
        return r;
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [33:0] key);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, key};
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(apply_request(req, key));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly keys already in the table or from a small colliding set, so hits are common
    function automatic logic [33:0] pick_key();
        logic [33:0] key;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (shadow_count > 0)
                    key = shadow_keys[$urandom_range(0, shadow_count - 1)];
                else
                    key = 34'($urandom_range(0, 15)) * 34'd625000000;
            end
            4, 5: key = 34'($urandom_range(0, 15)) * 34'd625000000;
            6, 7, 8: key = 34'({$urandom(), $urandom()});
            default: begin
                case ($urandom_range(0, 5))
                    0: key = '0;
                    1: key = 34'd1;
                    2: key = KEY_TOP;
                    3: key = KEY_TOP - 34'd1;
                    4: key = KEY_MAX - 34'd1;
                    default: key = KEY_MAX;
                endcase
            end
        endcase
        return key;
    endfunction

    function automatic logic [1:0] pick_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct) return REQ_INSERT;
        if (r < insert_pct + (100 - insert_pct) / 2) return REQ_REMOVE;
        if (r < 97) return REQ_SEARCH;
        return REQ_CLEAR;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, tdata=%h", o_m_tdata));
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tdata[1:0] !== exp_r.status)
                    report_mismatch($sformatf("status exp %0d got %0d",
                                              exp_r.status, o_m_tdata[1:0]));
                if (o_m_tdata[4:2] !== exp_r.position)
                    report_mismatch($sformatf("position exp %0d got %0d",
                                              exp_r.position, o_m_tdata[4:2]));
                if (o_m_tdata[8:5] !== exp_r.count)
                    report_mismatch($sformatf("entry_count exp %0d got %0d",
                                              exp_r.count, o_m_tdata[8:5]));
            end
        end
    end

    // result receiver: random stalls, bursts with tready held, and long hold-offs on request
    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end else begin
                gap = rx_no_gap ? 0 : $urandom_range(0, 11);
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic test_directed();
        send_request(REQ_SEARCH, 34'd5);            // empty table
        send_request(REQ_REMOVE, 34'd5);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, '0);               // goes in front of a larger key
        send_request(REQ_INSERT, KEY_TOP);
        send_request(REQ_INSERT, '0);               // duplicate at the bottom
        send_request(REQ_INSERT, KEY_MAX);          // duplicate at the top
        send_request(REQ_SEARCH, KEY_MAX);
        send_request(REQ_SEARCH, '0);
        send_request(REQ_INSERT, 34'd1);
        send_request(REQ_INSERT, KEY_TOP - 34'd1);
        send_request(REQ_INSERT, 34'd4242424242);
        send_request(REQ_INSERT, KEY_MAX - 34'd1);
        send_request(REQ_INSERT, 34'd2);            // table now full
        send_request(REQ_INSERT, 34'd77);
        send_request(REQ_INSERT, '0);               // full wins over duplicate
        send_request(REQ_SEARCH, 34'd77);
        send_request(REQ_REMOVE, 34'd4242424242);
        send_request(REQ_REMOVE, 34'd4242424242);
        send_request(REQ_REMOVE, KEY_MAX);
        send_request(REQ_REMOVE, '0);
        send_request(REQ_CLEAR, 34'h2_AAAA_5555);
        send_request(REQ_CLEAR, '0);                // clear of an empty table
        send_request(REQ_INSERT, 34'd12345);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        tx_no_gap = 1'b1;
        rx_hold = 300;
        for (n = 0; n < 30; n++)
            send_request(($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_SEARCH, pick_key());
        tx_no_gap = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        for (n = 0; n < 1000; n++) begin
            if (n % 100 == 0) begin
                tx_no_gap  = ($urandom_range(0, 3) == 0);
                rx_no_gap  = ($urandom_range(0, 3) == 0);
                insert_pct = $urandom_range(30, 60);
            end
            send_request(pick_req(), pick_key());
        end
        tx_no_gap = 1'b0;
        rx_no_gap = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = REQ_INSERT;
        shadow_count = 0;
        error_count  = 0;
        tx_no_gap    = 1'b0;
        rx_no_gap    = 1'b0;
        rx_hold      = 0;
        insert_pct   = 45;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
sim/tb_sorted_key_table.sv
